### design/median_filter_3x3_replicate_core_assert.svh
// Assertion macros for the median filter core.
// They expect clk and rst_n in the scope where they are used.
`ifndef MEDIAN_FILTER_3X3_REPLICATE_CORE_ASSERT_SVH
`define MEDIAN_FILTER_3X3_REPLICATE_CORE_ASSERT_SVH

// expr holds at every clock edge out of reset
`define MF3_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// cond at an edge implies expr at the same edge
`define MF3_ASSERT_IMPLIES(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

### design/mf3_pkg.sv
package mf3_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // result queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_in;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } result_t;

    // one window column: rows above, at and below the center row
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    // same column after sorting
    typedef struct packed {
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] md;
        logic [PIX_W-1:0] lo;
    } sorted_t;

    // per-column control toward the median network
    typedef struct packed {
        logic fire;
        logic first_col;
        logic last_col;
        logic frame_last;
    } col_ctrl_t;

endpackage

### design/mf3_ram.sv
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/mf3_median.sv
module mf3_median (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                col_valid,
    input  mf3_pkg::col_t       col,
    input  mf3_pkg::col_ctrl_t  col_ctrl,
    output logic                res_valid,
    output mf3_pkg::result_t    res
);

    function automatic logic [mf3_pkg::PIX_W-1:0] min2(
        input logic [mf3_pkg::PIX_W-1:0] a,
        input logic [mf3_pkg::PIX_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic [mf3_pkg::PIX_W-1:0] max2(
        input logic [mf3_pkg::PIX_W-1:0] a,
        input logic [mf3_pkg::PIX_W-1:0] b
    );
        return (a < b) ? b : a;
    endfunction

    function automatic logic [mf3_pkg::PIX_W-1:0] med3(
        input logic [mf3_pkg::PIX_W-1:0] a,
        input logic [mf3_pkg::PIX_W-1:0] b,
        input logic [mf3_pkg::PIX_W-1:0] c
    );
        logic [mf3_pkg::PIX_W-1:0] lo;
        logic [mf3_pkg::PIX_W-1:0] hi;
        lo = min2(a, b);
        hi = max2(a, b);
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

    // window: [0] newest column, [2] oldest
    mf3_pkg::sorted_t   win_reg [3];
    mf3_pkg::sorted_t   col_sorted;
    logic               s2_valid_reg;
    mf3_pkg::col_ctrl_t s2_ctrl_reg;

    mf3_pkg::sorted_t   left_col;
    mf3_pkg::sorted_t   center_col;
    mf3_pkg::sorted_t   right_col;
    logic [mf3_pkg::PIX_W-1:0] lo_max;
    logic [mf3_pkg::PIX_W-1:0] md_med;
    logic [mf3_pkg::PIX_W-1:0] hi_min;

    logic                      s3_valid_reg;
    logic                      s3_last_reg;
    logic [mf3_pkg::PIX_W-1:0] s3_lo_reg;
    logic [mf3_pkg::PIX_W-1:0] s3_md_reg;
    logic [mf3_pkg::PIX_W-1:0] s3_hi_reg;

    // sort the incoming column
    always_comb
    begin
        col_sorted.lo = min2(min2(col.top, col.mid), col.bot);
        col_sorted.hi = max2(max2(col.top, col.mid), col.bot);
        col_sorted.md = med3(col.top, col.mid, col.bot);
    end

    // window shift, one column per counted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0]   <= '0;
            win_reg[1]   <= '0;
            win_reg[2]   <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= col_valid && col_ctrl.fire;
            if (col_valid)
            begin
                win_reg[0] <= col_sorted;
                win_reg[1] <= win_reg[0];
                win_reg[2] <= win_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_valid)
        begin
            s2_ctrl_reg <= col_ctrl;
        end
    end

    // border replicate on the left and right, then reduce rows
    always_comb
    begin
        center_col = win_reg[1];
        left_col   = s2_ctrl_reg.first_col ? win_reg[1] : win_reg[2];
        right_col  = s2_ctrl_reg.last_col  ? win_reg[1] : win_reg[0];
        lo_max     = max2(max2(left_col.lo, center_col.lo), right_col.lo);
        md_med     = med3(left_col.md, center_col.md, right_col.md);
        hi_min     = min2(min2(left_col.hi, center_col.hi), right_col.hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_last_reg <= s2_ctrl_reg.frame_last;
            s3_lo_reg   <= lo_max;
            s3_md_reg   <= md_med;
            s3_hi_reg   <= hi_min;
        end
    end

    // final median of the three
    assign res_valid      = s3_valid_reg;
    assign res.pixel_out  = med3(s3_lo_reg, s3_md_reg, s3_hi_reg);
    assign res.frame_last = s3_last_reg;

endmodule

### design/median_filter_3x3_replicate_core.sv
// Channel | Handshake                    | Word
// item    | item_valid / item_stall      | mf3_pkg::item_t   {action, pixel_in}
// result  | result_valid / result_stall  | mf3_pkg::result_t {pixel_out, frame_last}
// config  | cfg_write                    | cfg_index, cfg_data
//
// One word per clock sustained while item_stall stays low; the line stores take one read
// and one write per word. A result passes the line store read, row reduction and final
// median before it is written to the result queue.
// Reset clears counters, window and queue; the line stores are never cleared.
// Results wait in an eight-entry queue; item_stall rises when eight results are
// queued or in flight.

`include "median_filter_3x3_replicate_core_assert.svh"

module median_filter_3x3_replicate_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  mf3_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output mf3_pkg::result_t                    result,
    input  logic                                cfg_write,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int OW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW = $clog2(MAX_HEIGHT + 2);
    localparam int LW = $clog2(MAX_WIDTH + 3);
    localparam int RST_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
    localparam int RST_H = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;
    localparam logic [mf3_pkg::OQ_CW-1:0] OQ_FULL = mf3_pkg::OQ_CW'(mf3_pkg::OQ_DEPTH);

    // configuration and frame counters
    logic [mf3_pkg::CFG_DATA_W-1:0] frame_width_reg;
    logic [mf3_pkg::CFG_DATA_W-1:0] frame_height_reg;
    logic [WW-1:0] cur_w_reg,   cur_w_next;
    logic [HW-1:0] cur_h_reg,   cur_h_next;
    logic [CW-1:0] pos_col_reg, pos_col_next;
    logic [PW-1:0] pos_row_reg, pos_row_next;
    logic [CW-1:0] ocol_reg,    ocol_next;
    logic [OW-1:0] orow_reg,    orow_next;
    logic [LW-1:0] lag_reg,     lag_next;

    logic [WW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;
    logic          accept;
    logic          is_drain;
    logic          pos_zero;
    logic          frame_done;
    logic          restart;
    logic          counted;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] col_eff;
    logic [PW-1:0] row_eff;
    logic [CW-1:0] ocol_eff;
    logic [OW-1:0] orow_eff;
    logic [LW-1:0] lag_eff;
    logic [LW-1:0] lag_inc;
    logic          fire;
    logic          first_col;
    logic          last_col;
    logic          last_row;
    logic          frame_end;

    // line store stage
    logic                          s1_valid_reg;
    logic                          s1_write_reg;
    logic                          s1_top_mid_reg;
    logic                          s1_fwd_reg;
    logic [CW-1:0]                 s1_cx_reg;
    logic [mf3_pkg::PIX_W-1:0]     s1_pix_reg;
    mf3_pkg::col_ctrl_t            s1_ctrl_reg;
    logic [mf3_pkg::PIX_W-1:0]     fwd_a_reg;
    logic [mf3_pkg::PIX_W-1:0]     fwd_b_reg;
    logic [mf3_pkg::PIX_W-1:0]     rd_a;
    logic [mf3_pkg::PIX_W-1:0]     rd_b;
    logic [mf3_pkg::PIX_W-1:0]     a_eff;
    logic [mf3_pkg::PIX_W-1:0]     b_eff;
    logic                          line_wr;
    mf3_pkg::col_t                 col;

    // result queue
    logic                          med_valid;
    mf3_pkg::result_t              med_res;
    mf3_pkg::result_t              fifo_mem_reg [mf3_pkg::OQ_DEPTH];
    logic [mf3_pkg::OQ_AW-1:0]     wr_ptr_reg;
    logic [mf3_pkg::OQ_AW-1:0]     rd_ptr_reg;
    logic [mf3_pkg::OQ_CW-1:0]     fifo_count_reg, fifo_count_next;
    logic [mf3_pkg::OQ_CW-1:0]     credit_reg,     credit_next;
    logic                          pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= mf3_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= mf3_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mf3_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                mf3_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    // frame size as latched at frame start: zero reads as one, cap at the maximum
    always_comb
    begin
        if (frame_width_reg == '0)
            w_clamp = WW'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_clamp = HW'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(frame_height_reg);
    end

    assign accept = item_valid && !item_stall;

    // word decode: frame start, drain filtering, output decision
    always_comb
    begin
        is_drain   = (item.action == mf3_pkg::ACT_DRAIN);
        pos_zero   = (pos_col_reg == '0) && (pos_row_reg == '0);
        frame_done = 32'(pos_row_reg) >= 32'(cur_h_reg);
        restart    = !is_drain && (pos_zero || frame_done);
        counted    = !is_drain || (!pos_zero && frame_done);

        w_eff    = restart ? w_clamp : cur_w_reg;
        h_eff    = restart ? h_clamp : cur_h_reg;
        col_eff  = restart ? '0 : pos_col_reg;
        row_eff  = restart ? '0 : pos_row_reg;
        ocol_eff = restart ? '0 : ocol_reg;
        orow_eff = restart ? '0 : orow_reg;
        lag_eff  = restart ? '0 : lag_reg;

        lag_inc   = lag_eff + LW'(1);
        fire      = counted && (32'(lag_inc) >= 32'(w_eff) + 32'd2);
        first_col = (ocol_eff == '0);
        last_col  = (32'(ocol_eff) + 32'd1 == 32'(w_eff));
        last_row  = (32'(orow_eff) + 32'd1 == 32'(h_eff));
        frame_end = fire && last_col && last_row;

        cur_w_next   = cur_w_reg;
        cur_h_next   = cur_h_reg;
        pos_col_next = pos_col_reg;
        pos_row_next = pos_row_reg;
        ocol_next    = ocol_reg;
        orow_next    = orow_reg;
        lag_next     = lag_reg;

        if (accept && counted)
        begin
            cur_w_next = w_eff;
            cur_h_next = h_eff;
            if (frame_end)
            begin
                pos_col_next = '0;
                pos_row_next = '0;
                ocol_next    = '0;
                orow_next    = '0;
                lag_next     = '0;
            end
            else
            begin
                // stream position, drains included
                if (32'(col_eff) + 32'd1 == 32'(w_eff))
                begin
                    pos_col_next = '0;
                    pos_row_next = row_eff + PW'(1);
                end
                else
                begin
                    pos_col_next = col_eff + CW'(1);
                    pos_row_next = row_eff;
                end
                // output position trails the stream by width plus two
                if (fire)
                begin
                    lag_next = lag_eff;
                    if (last_col)
                    begin
                        ocol_next = '0;
                        orow_next = orow_eff + OW'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_eff + CW'(1);
                        orow_next = orow_eff;
                    end
                end
                else
                begin
                    lag_next  = lag_inc;
                    ocol_next = ocol_eff;
                    orow_next = orow_eff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_w_reg   <= WW'(RST_W);
            cur_h_reg   <= HW'(RST_H);
            pos_col_reg <= '0;
            pos_row_reg <= '0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
            lag_reg     <= '0;
        end
        else
        begin
            cur_w_reg   <= cur_w_next;
            cur_h_reg   <= cur_h_next;
            pos_col_reg <= pos_col_next;
            pos_row_reg <= pos_row_next;
            ocol_reg    <= ocol_next;
            orow_reg    <= orow_next;
            lag_reg     <= lag_next;
        end
    end

    // line store stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && counted;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && counted)
        begin
            s1_write_reg         <= !is_drain;
            s1_top_mid_reg       <= (row_eff == PW'(1));
            s1_fwd_reg           <= s1_valid_reg && s1_write_reg && (s1_cx_reg == col_eff);
            s1_cx_reg            <= col_eff;
            s1_pix_reg           <= item.pixel_in;
            s1_ctrl_reg.fire       <= fire;
            s1_ctrl_reg.first_col  <= first_col;
            s1_ctrl_reg.last_col   <= last_col;
            s1_ctrl_reg.frame_last <= last_col && last_row;
        end
    end

    // line store A holds the previous row, B the row before it
    mf3_ram #(
        .WIDTH (mf3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (s1_cx_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (accept && counted),
        .rd_addr (col_eff),
        .rd_data (rd_a)
    );

    mf3_ram #(
        .WIDTH (mf3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (s1_cx_reg),
        .wr_data (a_eff),
        .rd_en   (accept && counted),
        .rd_addr (col_eff),
        .rd_data (rd_b)
    );

    // forward the previous write when it hit the same column
    always_comb
    begin
        line_wr = s1_valid_reg && s1_write_reg;
        a_eff   = s1_fwd_reg ? fwd_a_reg : rd_a;
        b_eff   = s1_fwd_reg ? fwd_b_reg : rd_b;
        col.mid = a_eff;
        col.top = s1_top_mid_reg ? a_eff : b_eff;
        col.bot = s1_write_reg ? s1_pix_reg : a_eff;
    end

    always_ff @(posedge clk)
    begin
        if (line_wr)
        begin
            fwd_a_reg <= s1_pix_reg;
            fwd_b_reg <= a_eff;
        end
    end

    mf3_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_valid (s1_valid_reg),
        .col       (col),
        .col_ctrl  (s1_ctrl_reg),
        .res_valid (med_valid),
        .res       (med_res)
    );

    // result queue; credits count queued plus in-flight results
    assign pop          = result_valid && !result_stall;
    assign result_valid = (fifo_count_reg != '0);
    assign result       = fifo_mem_reg[rd_ptr_reg];
    assign item_stall   = (credit_reg >= OQ_FULL);

    always_comb
    begin
        fifo_count_next = fifo_count_reg;
        if (med_valid && !pop)
            fifo_count_next = fifo_count_reg + mf3_pkg::OQ_CW'(1);
        else if (!med_valid && pop)
            fifo_count_next = fifo_count_reg - mf3_pkg::OQ_CW'(1);

        credit_next = credit_reg;
        if (accept && fire && !pop)
            credit_next = credit_reg + mf3_pkg::OQ_CW'(1);
        else if (!(accept && fire) && pop)
            credit_next = credit_reg - mf3_pkg::OQ_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            credit_reg     <= '0;
        end
        else
        begin
            fifo_count_reg <= fifo_count_next;
            credit_reg     <= credit_next;
            if (med_valid)
                wr_ptr_reg <= wr_ptr_reg + mf3_pkg::OQ_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + mf3_pkg::OQ_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (med_valid)
        begin
            fifo_mem_reg[wr_ptr_reg] <= med_res;
        end
    end

    // checks
    `MF3_ASSERT_ALWAYS(a_credit_covers_queue, credit_reg >= fifo_count_reg, "credit low")
    `MF3_ASSERT_IMPLIES(a_push_room, med_valid, fifo_count_reg != OQ_FULL, "push when full")
    `MF3_ASSERT_ALWAYS(a_lag_bound, 32'(lag_reg) <= 32'(cur_w_reg) + 32'd1, "lag past width")
    `MF3_ASSERT_ALWAYS(a_out_col_bound, 32'(ocol_reg) < 32'(cur_w_reg), "output column past width")

endmodule

### tb/tb_median_filter_3x3_replicate_core.sv
module tb_median_filter_3x3_replicate_core;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 1024;
    localparam int HIST_LEN    = 2 * MAX_W + 3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 8;

    typedef enum int {STYLE_RANDOM, STYLE_NARROW, STYLE_BINARY, STYLE_RAMP} pix_style_t;

    // Predicts the median stream and checks the words that come out
    class median_scoreboard;
        logic [mf3_pkg::CFG_DATA_W-1:0] reg_width;
        logic [mf3_pkg::CFG_DATA_W-1:0] reg_height;
        logic [mf3_pkg::PIX_W-1:0]      history [HIST_LEN];
        int unsigned                    in_col;
        int unsigned                    in_row;
        int unsigned                    out_pos;
        int unsigned                    word_count;
        int unsigned                    cur_w;
        int unsigned                    cur_h;
        mf3_pkg::result_t               expected_medians[$];
        int                             errors;

        function new();
            reg_width  = mf3_pkg::FRAME_WIDTH_RST;
            reg_height = mf3_pkg::FRAME_HEIGHT_RST;
            foreach (history[i])
                history[i] = '0;
            errors = 0;
            begin_frame();
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
            if (v < 1)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        // frame size is latched on the first pixel
        function void begin_frame();
            in_col     = 0;
            in_row     = 0;
            out_pos    = 0;
            word_count = 0;
            cur_w      = clamp_dim(reg_width, MAX_W);
            cur_h      = clamp_dim(reg_height, MAX_H);
        endfunction

        function void write_reg(logic [mf3_pkg::CFG_INDEX_W-1:0] idx,
                                logic [mf3_pkg::CFG_DATA_W-1:0] d);
            if (idx == mf3_pkg::REG_FRAME_WIDTH)
                reg_width = d;
            else if (idx == mf3_pkg::REG_FRAME_HEIGHT)
                reg_height = d;
        endfunction

        // sample with coordinates clamped to the frame edge
        function logic [mf3_pkg::PIX_W-1:0] pick(int x, int y);
            int unsigned idx;
            if (x < 0)
                x = 0;
            if (x > int'(cur_w) - 1)
                x = int'(cur_w) - 1;
            if (y < 0)
                y = 0;
            if (y > int'(cur_h) - 1)
                y = int'(cur_h) - 1;
            idx = y * cur_w + x;
            return history[idx % HIST_LEN];
        endfunction

        function logic [mf3_pkg::PIX_W-1:0] window_median(int unsigned k);
            logic [mf3_pkg::PIX_W-1:0] v [9];
            logic [mf3_pkg::PIX_W-1:0] t;
            int                        x;
            int                        y;
            int                        n;
            int                        j;
            x = k % cur_w;
            y = k / cur_w;
            n = 0;
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                begin
                    v[n] = pick(x + dx, y + dy);
                    n++;
                end
            // insertion sort, middle entry is the median
            for (int i = 1; i < 9; i++)
            begin
                t = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > t)
                begin
                    v[j + 1] = v[j];
                    j--;
                end
                v[j + 1] = t;
            end
            return v[4];
        endfunction

        function void note_word(mf3_pkg::item_t w);
            int unsigned      total;
            int unsigned      received;
            mf3_pkg::result_t exp_word;
            total    = cur_w * cur_h;
            received = in_row * cur_w + in_col;
            if (w.action == mf3_pkg::ACT_PIXEL)
            begin
                // a pixel when idle or after a full frame opens a new frame
                if (received == 0 || received >= total)
                begin
                    begin_frame();
                    total    = cur_w * cur_h;
                    received = 0;
                end
                history[received % HIST_LEN] = w.pixel_in;
                in_col++;
                if (in_col >= cur_w)
                begin
                    in_col = 0;
                    in_row++;
                end
                word_count++;
            end
            else
            begin
                // drain mid-frame or while idle does nothing
                if (received == 0 || received < total)
                    return;
                word_count++;
            end
            if (out_pos >= total || word_count < out_pos + cur_w + 2)
                return;
            exp_word.pixel_out  = window_median(out_pos);
            exp_word.frame_last = (out_pos == total - 1);
            expected_medians.push_back(exp_word);
            out_pos++;
            if (out_pos >= total)
            begin
                in_col     = 0;
                in_row     = 0;
                out_pos    = 0;
                word_count = 0;
            end
        endfunction

        function void check_result(mf3_pkg::result_t r);
            mf3_pkg::result_t exp_word;
            if (expected_medians.size() == 0)
            begin
                $error("unexpected result word: pixel_out %0d frame_last %0d",
                       r.pixel_out, r.frame_last);
                errors++;
                return;
            end
            exp_word = expected_medians.pop_front();
            if (r.pixel_out !== exp_word.pixel_out)
            begin
                $error("pixel_out mismatch: expected %0d, actual %0d",
                       exp_word.pixel_out, r.pixel_out);
                errors++;
            end
            if (r.frame_last !== exp_word.frame_last)
            begin
                $error("frame_last mismatch: expected %0d, actual %0d",
                       exp_word.frame_last, r.frame_last);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n        = 1'b0;
    logic                            item_valid   = 1'b0;
    logic                            item_stall;
    mf3_pkg::item_t                  item_word    = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    mf3_pkg::result_t                result_word;
    logic                            cfg_write    = 1'b0;
    logic [mf3_pkg::CFG_INDEX_W-1:0] cfg_index    = mf3_pkg::REG_FRAME_WIDTH;
    logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    median_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int words_sent    = 0;
    int cycle_count   = 0;

    median_filter_3x3_replicate_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_median_filter_3x3_replicate_core: FAIL");
            $finish;
        end
    end

    // result side: check accepted words, then pick next stall
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(result_word);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [mf3_pkg::PIX_W-1:0] next_pixel(pix_style_t s, int idx);
        unique case (s)
            STYLE_NARROW: return 8'(120 + $urandom_range(3));
            STYLE_BINARY: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            STYLE_RAMP:   return 8'((idx * 7 + $urandom_range(3)) & 255);
            default:      return 8'($urandom_range(255));
        endcase
    endfunction

    // offer one word, idling first at random; valid stays up after acceptance
    task automatic send_word(logic act, logic [mf3_pkg::PIX_W-1:0] pix);
        mf3_pkg::item_t w;
        w.action   = act;
        w.pixel_in = pix;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_word  <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_word(w);
    endtask

    // drop valid and wait until every expected median is out
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_frame_size(logic [mf3_pkg::CFG_DATA_W-1:0] wv,
                                    logic [mf3_pkg::CFG_DATA_W-1:0] hv);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= mf3_pkg::REG_FRAME_WIDTH;
        cfg_data  <= wv;
        @(posedge clk);
        sb.write_reg(mf3_pkg::REG_FRAME_WIDTH, wv);
        cfg_index <= mf3_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= hv;
        @(posedge clk);
        sb.write_reg(mf3_pkg::REG_FRAME_HEIGHT, hv);
        cfg_write <= 1'b0;
    endtask

    // pixels of one frame, an optional stray drain before pixel drain_at, then flush
    task automatic run_frame(int w, int h, pix_style_t style, int drains, int drain_at);
        int n;
        n = w * h;
        for (int i = 0; i < n; i++)
        begin
            if (i == drain_at)
                send_word(mf3_pkg::ACT_DRAIN, 8'($urandom_range(255)));
            send_word(mf3_pkg::ACT_PIXEL, next_pixel(style, i));
        end
        repeat (drains) send_word(mf3_pkg::ACT_DRAIN, 8'($urandom_range(255)));
        words_sent += n + drains;
    endtask

    initial
    begin
        logic [mf3_pkg::CFG_DATA_W-1:0] wreg;
        logic [mf3_pkg::CFG_DATA_W-1:0] hreg;
        int                             eff_w;
        int                             eff_h;
        int                             sel;
        int                             drains;
        int                             drain_at;
        int                             phase_end;

        send_idle_pct = 17;
        recv_idle_pct = 60;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // drains while idle are ignored
        send_word(mf3_pkg::ACT_DRAIN, 8'hFF);
        send_word(mf3_pkg::ACT_DRAIN, 8'h00);

        // zero registers give a 1x1 frame; one extra drain after the output
        write_frame_size(11'd0, 11'd0);
        run_frame(1, 1, STYLE_BINARY, 3, -1);

        // 3x2 of extremes with a drain in the middle of the frame
        write_frame_size(11'd3, 11'd2);
        run_frame(3, 2, STYLE_BINARY, 4, 2);

        // size change mid-frame waits for the next frame; then the pending
        // outputs of the 2x2 frame are cut off by a new pixel
        write_frame_size(11'd2, 11'd2);
        send_word(mf3_pkg::ACT_PIXEL, 8'd17);
        send_word(mf3_pkg::ACT_PIXEL, 8'd200);
        write_frame_size(11'd3, 11'd1);
        send_word(mf3_pkg::ACT_PIXEL, 8'd90);
        send_word(mf3_pkg::ACT_PIXEL, 8'd3);
        send_word(mf3_pkg::ACT_DRAIN, 8'd0);
        run_frame(3, 1, STYLE_RANDOM, 4, -1);
        eff_w = 3;
        eff_h = 1;

        // random frames over three idling patterns
        for (int ph = 0; ph < 3; ph++)
        begin
            unique case (ph)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 60;
                end
                1:
                begin
                    send_idle_pct = 60;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // long result hold-off fills the block and stalls input
                    write_frame_size(11'd16, 11'd6);
                    eff_w        = 16;
                    eff_h        = 6;
                    hold_request = 400;
                    run_frame(16, 6, STYLE_RANDOM, 17, -1);
                end
            endcase
            phase_end = words_sent + 240;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(99) < 60)
                begin
                    sel = $urandom_range(99);
                    if (sel < 70)
                    begin
                        wreg = 11'($urandom_range(1, 10));
                        hreg = 11'($urandom_range(1, 6));
                    end
                    else if (sel < 85)
                    begin
                        wreg = 11'($urandom_range(11, 40));
                        hreg = 11'($urandom_range(1, 4));
                    end
                    else if (sel < 92)
                    begin
                        wreg = 11'($urandom_range(1));
                        hreg = 11'($urandom_range(1, 12));
                    end
                    else
                    begin
                        wreg = 11'($urandom_range(1, 6));
                        hreg = 11'($urandom_range(1));
                    end
                    write_frame_size(wreg, hreg);
                    eff_w = sb.clamp_dim(wreg, MAX_W);
                    eff_h = sb.clamp_dim(hreg, MAX_H);
                end
                sel = $urandom_range(99);
                if (sel < 80)
                    drains = eff_w + 1;
                else if (sel < 90)
                    drains = $urandom_range(eff_w);
                else
                    drains = eff_w + 1 + $urandom_range(1, 3);
                drain_at = ($urandom_range(99) < 20) ? $urandom_range(eff_w * eff_h - 1) : -1;
                run_frame(eff_w, eff_h, pix_style_t'($urandom_range(3)), drains, drain_at);
            end
        end

        wait_drained();
        if (sb.expected_medians.size() != 0)
        begin
            $error("%0d expected medians never arrived", sb.expected_medians.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb_median_filter_3x3_replicate_core: PASS");
        else
            $display("tb_median_filter_3x3_replicate_core: FAIL");
        $finish;
    end

endmodule
